// File: hdl/quotient_digit_estimate_check_unit_assert.svh
// Assertion helpers for the quotient digit unit.
`ifndef QUOTIENT_DIGIT_ESTIMATE_CHECK_UNIT_ASSERT_SVH
`define QUOTIENT_DIGIT_ESTIMATE_CHECK_UNIT_ASSERT_SVH

// Property holds on every clock edge outside reset.
`define QDEC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Antecedent implies consequent on the same edge.
`define QDEC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

// File: hdl/qdec_pkg.sv
package qdec_pkg;

  localparam int unsigned W = 32;
  localparam int unsigned LATENCY = W + 8;

  typedef struct packed {
    logic [W-1:0] dividend_w0;
    logic [W-1:0] dividend_w1;
    logic [W-1:0] dividend_w2;
    logic [W-1:0] dividend_w3;
    logic [W-1:0] divisor_w1;
    logic [W-1:0] divisor_w2;
    logic [W-1:0] divisor_w3;
  } qdec_in_t;

  typedef struct packed {
    logic [W-1:0] quotient_digit;
    logic [W-1:0] rest_w0;
    logic [W-1:0] rest_w1;
    logic [W-1:0] rest_w2;
    logic [W-1:0] rest_w3;
    logic         overshoot;
  } qdec_out_t;

endpackage

// File: hdl/quotient_digit_estimate_check_unit.sv
// Channel  | Signals                 | Handshake
// ---------+-------------------------+-------------------------------------
// command  | start_i, in_i, busy_o   | taken when start_i high, busy_o low
// result   | done_o, out_o           | one-cycle strobe, no backpressure
//
// A command passes the one-bit-per-stage divider, then u_fix1, u_fix2 and u_rest.
// A new transaction can be taken every cycle; busy_o stays low.
// Reset clears only the valid bits of the pipeline.
// The receiver cannot stall, so the pipeline never holds.
`include "quotient_digit_estimate_check_unit_assert.svh"

module quotient_digit_estimate_check_unit import qdec_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  qdec_in_t  in_i,
  output logic      busy_o,
  output logic      done_o,
  output qdec_out_t out_o
);

  logic         div_valid, fix1_valid, fix2_valid;
  qdec_in_t     div_data, fix1_data, fix2_data;
  logic [W-1:0] div_q, fix1_q, fix2_q;
  logic         accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  qdec_div u_div (
    .clk_i, .rst_ni,
    .valid_i (accept), .data_i (in_i),
    .valid_o (div_valid), .data_o (div_data), .q_o (div_q)
  );

  qdec_fix u_fix1 (
    .clk_i, .rst_ni,
    .valid_i (div_valid), .data_i (div_data), .q_i (div_q),
    .valid_o (fix1_valid), .data_o (fix1_data), .q_o (fix1_q)
  );

  qdec_fix u_fix2 (
    .clk_i, .rst_ni,
    .valid_i (fix1_valid), .data_i (fix1_data), .q_i (fix1_q),
    .valid_o (fix2_valid), .data_o (fix2_data), .q_o (fix2_q)
  );

  qdec_rest u_rest (
    .clk_i, .rst_ni,
    .valid_i (fix2_valid), .data_i (fix2_data), .q_i (fix2_q),
    .valid_o (done_o), .out_o (out_o)
  );

  `QDEC_ASSERT(a_never_busy, clk_i, rst_ni, !busy_o)
  `QDEC_ASSERT_IMPL(a_done_has_cmd, clk_i, rst_ni, done_o, $past(accept, LATENCY))
  `QDEC_ASSERT_IMPL(a_fix_to_done, clk_i, rst_ni, fix2_valid, ##3 done_o)

endmodule

// File: hdl/qdec_div.sv
module qdec_div import qdec_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  qdec_in_t data_i,
  output logic     valid_o,
  output qdec_in_t data_o,
  output logic [W-1:0] q_o
);

  logic           valid_q [W+1];
  qdec_in_t       data_q  [W+1];
  logic [W-1:0]   rem_q   [W+1];
  logic [W-1:0]   lo_q    [W+1];
  logic [W-1:0]   quo_q   [W+1];
  logic           sat_q   [W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q[0] <= data_i;
    rem_q[0]  <= data_i.dividend_w0;
    lo_q[0]   <= data_i.dividend_w1;
    quo_q[0]  <= '0;
    sat_q[0]  <= (data_i.dividend_w0 >= data_i.divisor_w1);
  end

  for (genvar k = 1; k <= W; k++) begin : g_step
    logic [W:0]   shifted;
    logic [W:0]   dvs;
    logic         take;
    logic [W-1:0] rem_d;

    always_comb begin
      shifted = {rem_q[k-1], lo_q[k-1][W-1]};
      dvs     = {1'b0, data_q[k-1].divisor_w1};
      take    = (shifted >= dvs);
      rem_d   = take ? W'(shifted - dvs) : shifted[W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      data_q[k] <= data_q[k-1];
      rem_q[k]  <= rem_d;
      lo_q[k]   <= {lo_q[k-1][W-2:0], 1'b0};
      quo_q[k]  <= {quo_q[k-1][W-2:0], take};
      sat_q[k]  <= sat_q[k-1];
    end
  end

  assign valid_o = valid_q[W];
  assign data_o  = data_q[W];
  assign q_o     = sat_q[W] ? {W{1'b1}} : quo_q[W];

endmodule

// File: hdl/qdec_fix.sv
module qdec_fix import qdec_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  qdec_in_t     data_i,
  input  logic [W-1:0] q_i,
  output logic         valid_o,
  output qdec_in_t     data_o,
  output logic [W-1:0] q_o
);

  logic           valid1_q, valid2_q;
  qdec_in_t       data1_q, data2_q;
  logic [W-1:0]   q1_q, q2_q;
  logic [2*W-1:0] t_q, l_q;
  logic [2*W-1:0] r;
  logic           big;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_comb begin
    r   = {data1_q.dividend_w0, data1_q.dividend_w1} - t_q;
    big = (r[2*W-1:W] == '0) && (l_q > {r[W-1:0], data1_q.dividend_w2});
  end

  always_ff @(posedge clk_i) begin
    data1_q <= data_i;
    q1_q    <= q_i;
    t_q     <= q_i * data_i.divisor_w1;
    l_q     <= q_i * data_i.divisor_w2;
    data2_q <= data1_q;
    q2_q    <= big ? W'(q1_q - 1'b1) : q1_q;
  end

  assign valid_o = valid2_q;
  assign data_o  = data2_q;
  assign q_o     = q2_q;

endmodule

// File: hdl/qdec_rest.sv
module qdec_rest import qdec_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  qdec_in_t     data_i,
  input  logic [W-1:0] q_i,
  output logic         valid_o,
  output qdec_out_t    out_o
);

  logic           v1_q, v2_q, v3_q;
  qdec_in_t       d1_q, d2_q;
  logic [W-1:0]   q1_q, q2_q;
  logic [2*W-1:0] m1_q, m2_q, m3_q;
  logic [4*W-1:0] p_q;
  logic [4*W:0]   diff;
  qdec_out_t      out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign diff = {1'b0, d2_q.dividend_w0, d2_q.dividend_w1, d2_q.dividend_w2,
                 d2_q.dividend_w3} - {1'b0, p_q};

  always_ff @(posedge clk_i) begin
    d1_q <= data_i;
    q1_q <= q_i;
    m1_q <= q_i * data_i.divisor_w1;
    m2_q <= q_i * data_i.divisor_w2;
    m3_q <= q_i * data_i.divisor_w3;
    d2_q <= d1_q;
    q2_q <= q1_q;
    p_q  <= {m1_q, {2*W{1'b0}}} + {{W{1'b0}}, m2_q, {W{1'b0}}}
          + {{2*W{1'b0}}, m3_q};
    out_q.quotient_digit <= q2_q;
    out_q.rest_w0        <= diff[4*W-1:3*W];
    out_q.rest_w1        <= diff[3*W-1:2*W];
    out_q.rest_w2        <= diff[2*W-1:W];
    out_q.rest_w3        <= diff[W-1:0];
    out_q.overshoot      <= diff[4*W];
  end

  assign valid_o = v3_q;
  assign out_o   = out_q;

endmodule
